// ----- hw/rtl/bmm_pkg.sv -----
// ----------------------------------------------------------------------------
// bmm_pkg
// Shared types and constants of the binary mask metric block.
// ----------------------------------------------------------------------------
package bmm_pkg;

  // counter width and parameter defaults
  localparam int CNT_W            = 23;
  localparam int MAX_PIXELS_DEF   = 4194304;
  localparam int FRAC_BITS_DEF    = 14;

  // queue between front and back
  localparam int QUEUE_DEPTH      = 4;
  localparam int QUEUE_PTR_W      = $clog2(QUEUE_DEPTH);

  // pixel pair classes
  localparam logic [1:0] CLS_TP   = 2'd0;
  localparam logic [1:0] CLS_TN   = 2'd1;
  localparam logic [1:0] CLS_FP   = 2'd2;
  localparam logic [1:0] CLS_FN   = 2'd3;

  // classified item in the queue
  typedef struct packed {
    logic [1:0] cls;
    logic       last;
  } entry_t;

  // frame counts handed to the math unit
  typedef struct packed {
    logic [CNT_W-1:0] tp;
    logic [CNT_W-1:0] tn;
    logic [CNT_W-1:0] fp;
    logic [CNT_W-1:0] fn;
    logic             sat;
  } snap_t;

  // finished metrics
  typedef struct packed {
    logic signed [15:0] mcc;
    logic [14:0]        f1;
    logic               mcc_fb;
    logic               f1_fb;
    logic               ovf;
  } result_t;

endpackage

// ----- hw/rtl/bmm_pixel_if.sv -----
// ----------------------------------------------------------------------------
// bmm_pixel_if
// Pixel pair channel: valid, ready, one reference/segmentation pair and a last flag.
// ----------------------------------------------------------------------------
interface bmm_pixel_if;
  logic       valid;
  logic       ready;
  logic [7:0] ref_pixel;
  logic [7:0] seg_pixel;
  logic       last_pixel;

  modport source (output valid, output ref_pixel, output seg_pixel,
                  output last_pixel, input ready);
  modport sink   (input valid, input ref_pixel, input seg_pixel,
                  input last_pixel, output ready);
endinterface

// ----- hw/rtl/bmm_result_if.sv -----
// ----------------------------------------------------------------------------
// bmm_result_if
// Metric result channel: valid, ready and the per-frame metrics.
// ----------------------------------------------------------------------------
interface bmm_result_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] mcc_value;
  logic [14:0]        f1_value;
  logic               mcc_fallback;
  logic               f1_fallback;
  logic               count_overflow;

  modport source (output valid, output mcc_value, output f1_value,
                  output mcc_fallback, output f1_fallback,
                  output count_overflow, input ready);
  modport sink   (input valid, input mcc_value, input f1_value,
                  input mcc_fallback, input f1_fallback,
                  input count_overflow, output ready);
endinterface

// ----- hw/rtl/binary_mask_mcc_f1_metric_top.sv -----
// Throughput: one pixel pair per cycle while counting; the input stalls only
// when a frame's last item waits for the previous frame's math to be taken by
// the output register and the four-item queue has filled behind it.
// Reset: synchronous rst clears counters, queue, sequencer and output valid.
// ----------------------------------------------------------------------------
// binary_mask_mcc_f1_metric_top
// MCC and F1 score of a reference mask against a segmentation, per frame.
// ----------------------------------------------------------------------------
module binary_mask_mcc_f1_metric_top #(
  parameter int MAX_PIXELS = bmm_pkg::MAX_PIXELS_DEF,
  parameter int FRAC_BITS  = bmm_pkg::FRAC_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  bmm_pixel_if.sink    pixel,
  bmm_result_if.source result
);
  import bmm_pkg::*;

  logic    q_full;
  logic    push;
  entry_t  push_data;
  logic    pop;
  entry_t  pop_data;
  logic    q_valid;
  logic    calc_idle;
  logic    calc_done;
  logic    calc_start;
  logic    calc_ack;
  snap_t   calc_snap;
  result_t calc_res;

  // front: accept and classify
  bmm_front u_front (
    .pixel     (pixel),
    .q_full    (q_full),
    .push      (push),
    .push_data (push_data)
  );

  // queue between front and back
  bmm_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (pop),
    .pop_data  (pop_data),
    .not_empty (q_valid)
  );

  // frame math
  bmm_calc #(.FRAC_BITS(FRAC_BITS)) u_calc (
    .clk   (clk),
    .rst   (rst),
    .start (calc_start),
    .snap  (calc_snap),
    .idle  (calc_idle),
    .done  (calc_done),
    .ack   (calc_ack),
    .res   (calc_res)
  );

  // back: counting and result register
  bmm_back #(.MAX_PIXELS(MAX_PIXELS)) u_back (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (q_valid),
    .q_data     (pop_data),
    .pop        (pop),
    .calc_idle  (calc_idle),
    .calc_done  (calc_done),
    .calc_res   (calc_res),
    .calc_start (calc_start),
    .calc_snap  (calc_snap),
    .calc_ack   (calc_ack),
    .result     (result)
  );
endmodule

// ----- hw/rtl/bmm_queue.sv -----
// ----------------------------------------------------------------------------
// bmm_queue
// Small FIFO of classified items between the front and the back.
// ----------------------------------------------------------------------------
module bmm_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  bmm_pkg::entry_t push_data,
  output logic            full,
  input  logic            pop,
  output bmm_pkg::entry_t pop_data,
  output logic            not_empty
);
  import bmm_pkg::*;

  entry_t                 mem [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr;
  logic [QUEUE_PTR_W-1:0] rd_ptr;
  logic [QUEUE_PTR_W:0]   count;

  assign full      = (count == (QUEUE_PTR_W+1)'(QUEUE_DEPTH));
  assign not_empty = (count != '0);
  assign pop_data  = mem[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end
endmodule

// ----- hw/rtl/bmm_front.sv -----
// ----------------------------------------------------------------------------
// bmm_front
// Accepts pixel pairs and classifies them as TP, TN, FP or FN.
// ----------------------------------------------------------------------------
module bmm_front (
  bmm_pixel_if.sink       pixel,
  input  logic            q_full,
  output logic            push,
  output bmm_pkg::entry_t push_data
);
  import bmm_pkg::*;

  logic is_ref;
  logic is_seg;

  assign is_ref      = (pixel.ref_pixel != 8'd0);
  assign is_seg      = (pixel.seg_pixel != 8'd0);
  assign pixel.ready = !q_full;
  assign push        = pixel.valid && !q_full;

  // class of the pair
  always_comb begin
    push_data.last = pixel.last_pixel;
    if (is_ref && is_seg) begin
      push_data.cls = CLS_TP;
    end else if (!is_ref && !is_seg) begin
      push_data.cls = CLS_TN;
    end else if (is_seg) begin
      push_data.cls = CLS_FP;
    end else begin
      push_data.cls = CLS_FN;
    end
  end
endmodule

// ----- hw/rtl/bmm_calc.sv -----
// ----------------------------------------------------------------------------
// bmm_calc
// Per-frame math: MCC through one shared 32x32 multiplier, a bit-serial
// divider and a bitwise square root; F1 through the same divider.
// ----------------------------------------------------------------------------
module bmm_calc #(
  parameter int FRAC_BITS = bmm_pkg::FRAC_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  bmm_pkg::snap_t   snap,
  output logic             idle,
  output logic             done,
  input  logic             ack,
  output bmm_pkg::result_t res
);
  import bmm_pkg::*;

  localparam int CW   = CNT_W;
  localparam int SW   = CW + 1;
  localparam int PW   = 2 * CW;
  localparam int HW   = 24;
  localparam int MXW  = 2 * HW;
  localparam int ABW  = 4 * HW;
  localparam int NNW  = ABW + 2 * FRAC_BITS;
  localparam int RW   = ABW + 1;
  localparam int QW   = 2 * FRAC_BITS + 1;
  localparam int QSW  = FRAC_BITS + 1;
  localparam int DCW  = $clog2(NNW);
  localparam int SBW  = $clog2(QSW);
  localparam int FDW  = CW + 3;

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_P1     = 4'd1;
  localparam logic [3:0] ST_P2     = 4'd2;
  localparam logic [3:0] ST_A      = 4'd3;
  localparam logic [3:0] ST_B      = 4'd4;
  localparam logic [3:0] ST_AB     = 4'd5;
  localparam logic [3:0] ST_PP     = 4'd6;
  localparam logic [3:0] ST_PP_END = 4'd7;
  localparam logic [3:0] ST_DIV    = 4'd8;
  localparam logic [3:0] ST_SQ_MUL = 4'd9;
  localparam logic [3:0] ST_SQ_CMP = 4'd10;
  localparam logic [3:0] ST_F1     = 4'd11;
  localparam logic [3:0] ST_DONE   = 4'd12;

  logic [3:0]     state;
  snap_t          cnt;
  logic           mfb;
  logic           ffb;
  logic           eq_fg;
  logic           neg;
  logic [PW-1:0]  p1;
  logic [PW-1:0]  p2;
  logic [PW-1:0]  mag;
  logic [MXW-1:0] a_prod;
  logic [MXW-1:0] mx;
  logic [MXW-1:0] my;
  logic [ABW-1:0] ab;
  logic [ABW-1:0] acc;
  logic [1:0]     pp_idx;
  logic [1:0]     pp_sh;
  logic           pp_first;
  logic           pp_sel;
  logic [63:0]    prod;
  logic [31:0]    mul_x;
  logic [31:0]    mul_y;
  logic [NNW-1:0] num;
  logic [ABW-1:0] den;
  logic [ABW-1:0] rem;
  logic [QW-1:0]  quot;
  logic [DCW-1:0] div_cnt;
  logic           div_sel;
  logic [QW-1:0]  dq;
  logic [QSW-1:0] sq_q;
  logic [SBW-1:0] sq_bit;

  logic [ABW-1:0] pp_term;
  logic [ABW-1:0] acc_sum;
  logic [RW-1:0]  div_sh;
  logic           div_ge;
  logic [QSW-1:0] sq_c;
  logic [SW-1:0]  sum_tfn;
  logic [SW-1:0]  sum_tfp;
  logic [SW-1:0]  sum_nfn;
  logic [SW-1:0]  sum_nfp;
  logic [FDW-1:0] f1_den;

  assign idle = (state == ST_IDLE);
  assign done = (state == ST_DONE);

  // marginal sums
  assign sum_tfn = SW'(cnt.tp) + SW'(cnt.fn);
  assign sum_tfp = SW'(cnt.tp) + SW'(cnt.fp);
  assign sum_nfn = SW'(cnt.tn) + SW'(cnt.fn);
  assign sum_nfp = SW'(cnt.tn) + SW'(cnt.fp);
  assign f1_den  = (FDW'(cnt.tp) << 1) + FDW'(cnt.fp) + FDW'(cnt.fn);

  // shared multiplier operand select
  always_comb begin
    mul_x = '0;
    mul_y = '0;
    case (state)
      ST_P1: begin
        mul_x = 32'(cnt.tp);
        mul_y = 32'(cnt.tn);
      end
      ST_P2: begin
        mul_x = 32'(cnt.fp);
        mul_y = 32'(cnt.fn);
      end
      ST_A: begin
        mul_x = 32'(sum_tfn);
        mul_y = 32'(sum_tfp);
      end
      ST_B: begin
        mul_x = 32'(sum_nfn);
        mul_y = 32'(sum_nfp);
      end
      ST_PP: begin
        mul_x = pp_idx[1] ? 32'(mx[MXW-1:HW]) : 32'(mx[HW-1:0]);
        mul_y = pp_idx[0] ? 32'(my[MXW-1:HW]) : 32'(my[HW-1:0]);
      end
      ST_SQ_MUL: begin
        mul_x = 32'(sq_c);
        mul_y = 32'(sq_c);
      end
      default: begin
        mul_x = '0;
        mul_y = '0;
      end
    endcase
  end

  // partial product alignment
  always_comb begin
    case (pp_sh)
      2'd0:    pp_term = ABW'(prod);
      2'd1:    pp_term = ABW'(prod) << HW;
      default: pp_term = ABW'(prod) << (2 * HW);
    endcase
  end
  assign acc_sum = acc + pp_term;

  // divider step and root candidate
  assign div_sh = {rem, num[NNW-1]};
  assign div_ge = (div_sh >= {1'b0, den});
  assign sq_c   = sq_q | (QSW'(1) << sq_bit);

  // multiplier register
  always_ff @(posedge clk) begin
    prod <= mul_x * mul_y;
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      case (state)
        ST_IDLE: begin
          if (start) begin
            cnt   <= snap;
            mfb   <= (snap.tp == '0 && snap.fn == '0) || (snap.tp == '0 && snap.fp == '0)
                  || (snap.tn == '0 && snap.fn == '0) || (snap.tn == '0 && snap.fp == '0);
            ffb   <= (snap.tp == '0);
            eq_fg <= (snap.fn == snap.fp);
            state <= ST_P1;
          end
        end
        ST_P1: begin
          state <= mfb ? ST_F1 : ST_P2;
        end
        ST_P2: begin
          p1    <= PW'(prod);
          state <= ST_A;
        end
        ST_A: begin
          p2    <= PW'(prod);
          state <= ST_B;
        end
        ST_B: begin
          a_prod <= MXW'(prod);
          neg    <= (p2 > p1);
          mag    <= (p2 > p1) ? (p2 - p1) : (p1 - p2);
          state  <= ST_AB;
        end
        ST_AB: begin
          mx       <= a_prod;
          my       <= MXW'(prod);
          acc      <= '0;
          pp_idx   <= '0;
          pp_first <= 1'b1;
          pp_sel   <= 1'b0;
          state    <= ST_PP;
        end
        ST_PP: begin
          if (!pp_first) begin
            acc <= acc_sum;
          end
          pp_first <= 1'b0;
          pp_sh    <= 2'(pp_idx[1]) + 2'(pp_idx[0]);
          pp_idx   <= pp_idx + 1'b1;
          if (pp_idx == 2'd3) begin
            state <= ST_PP_END;
          end
        end
        ST_PP_END: begin
          if (!pp_sel) begin
            // product of the marginals done, now the squared numerator
            ab       <= acc_sum;
            mx       <= MXW'(mag);
            my       <= MXW'(mag);
            acc      <= '0;
            pp_idx   <= '0;
            pp_first <= 1'b1;
            pp_sel   <= 1'b1;
            state    <= ST_PP;
          end else begin
            num     <= {acc_sum, {(2*FRAC_BITS){1'b0}}};
            den     <= ab;
            rem     <= '0;
            quot    <= '0;
            div_cnt <= DCW'(NNW - 1);
            div_sel <= 1'b0;
            state   <= ST_DIV;
          end
        end
        ST_DIV: begin
          rem  <= div_ge ? ABW'(div_sh - {1'b0, den}) : ABW'(div_sh);
          quot <= {quot[QW-2:0], div_ge};
          num  <= num << 1;
          if (div_cnt == '0) begin
            if (!div_sel) begin
              state <= ST_SQ_MUL;
            end else begin
              state <= ST_DONE;
            end
          end else begin
            div_cnt <= div_cnt - 1'b1;
          end
        end
        ST_SQ_MUL: begin
          if (!div_sel) begin
            dq     <= quot;
            sq_q   <= '0;
            sq_bit <= SBW'(FRAC_BITS);
            div_sel <= 1'b1;
            state  <= ST_SQ_MUL;
          end else begin
            state <= ST_SQ_CMP;
          end
        end
        ST_SQ_CMP: begin
          if (prod <= 64'(dq)) begin
            sq_q <= sq_c;
          end
          if (sq_bit == '0) begin
            state <= ST_F1;
          end else begin
            sq_bit <= sq_bit - 1'b1;
            state  <= ST_SQ_MUL;
          end
        end
        ST_F1: begin
          if (ffb) begin
            state <= ST_DONE;
          end else begin
            num     <= NNW'({cnt.tp, 1'b0}) << FRAC_BITS;
            den     <= ABW'(f1_den);
            rem     <= '0;
            quot    <= '0;
            div_cnt <= DCW'(NNW - 1);
            div_sel <= 1'b1;
            state   <= ST_DIV;
          end
        end
        ST_DONE: begin
          if (ack) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // clamp into the result fields
  logic [31:0] mcc_m;
  logic        mcc_neg;
  logic [63:0] f1_m;

  always_comb begin
    if (mfb) begin
      mcc_m   = eq_fg ? (32'd1 << FRAC_BITS) : 32'd0;
      mcc_neg = 1'b0;
    end else begin
      mcc_m   = 32'(sq_q);
      mcc_neg = neg;
    end
    if (ffb) begin
      f1_m = eq_fg ? (64'd1 << FRAC_BITS) : 64'd0;
    end else begin
      f1_m = 64'(quot);
    end
    if (mcc_neg) begin
      res.mcc = (mcc_m > 32'd32768) ? 16'sh8000 : -$signed(16'(mcc_m));
    end else begin
      res.mcc = (mcc_m > 32'd32767) ? 16'sh7fff : $signed(16'(mcc_m));
    end
    res.f1     = (f1_m > 64'd32767) ? 15'h7fff : 15'(f1_m);
    res.mcc_fb = mfb;
    res.f1_fb  = ffb;
    res.ovf    = cnt.sat;
  end
endmodule

// ----- hw/rtl/bmm_back.sv -----
// ----------------------------------------------------------------------------
// bmm_back
// Drains the queue, keeps the four saturating counters, starts the frame
// math on the last item and holds the result in an output register.
// ----------------------------------------------------------------------------
module bmm_back #(
  parameter int MAX_PIXELS = bmm_pkg::MAX_PIXELS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_valid,
  input  bmm_pkg::entry_t  q_data,
  output logic             pop,
  input  logic             calc_idle,
  input  logic             calc_done,
  input  bmm_pkg::result_t calc_res,
  output logic             calc_start,
  output bmm_pkg::snap_t   calc_snap,
  output logic             calc_ack,
  bmm_result_if.source     result
);
  import bmm_pkg::*;

  localparam longint CNT_MAX = (longint'(1) << CNT_W) - 1;
  localparam logic [CNT_W-1:0] LIMIT =
    (longint'(MAX_PIXELS) < CNT_MAX) ? CNT_W'(MAX_PIXELS) : CNT_W'(CNT_MAX);

  snap_t   cnt;
  snap_t   cnt_next;
  result_t out_reg;
  logic    out_valid;

  assign pop        = q_valid && (!q_data.last || calc_idle);
  assign calc_start = pop && q_data.last;
  assign calc_snap  = cnt_next;
  assign calc_ack   = calc_done && (!out_valid || result.ready);

  // saturating bump of the counter for this class
  always_comb begin
    cnt_next = cnt;
    case (q_data.cls)
      CLS_TP: begin
        if (cnt.tp >= LIMIT) cnt_next.sat = 1'b1;
        else cnt_next.tp = cnt.tp + 1'b1;
      end
      CLS_TN: begin
        if (cnt.tn >= LIMIT) cnt_next.sat = 1'b1;
        else cnt_next.tn = cnt.tn + 1'b1;
      end
      CLS_FP: begin
        if (cnt.fp >= LIMIT) cnt_next.sat = 1'b1;
        else cnt_next.fp = cnt.fp + 1'b1;
      end
      default: begin
        if (cnt.fn >= LIMIT) cnt_next.sat = 1'b1;
        else cnt_next.fn = cnt.fn + 1'b1;
      end
    endcase
  end

  // counters, cleared after the last item of a frame
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (pop) begin
      cnt <= q_data.last ? '0 : cnt_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      if (calc_ack) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (calc_ack) begin
      out_reg <= calc_res;
    end
  end

  assign result.valid          = out_valid;
  assign result.mcc_value      = out_reg.mcc;
  assign result.f1_value       = out_reg.f1;
  assign result.mcc_fallback   = out_reg.mcc_fb;
  assign result.f1_fallback    = out_reg.f1_fb;
  assign result.count_overflow = out_reg.ovf;
endmodule

// ----- bench/binary_mask_mcc_f1_metric_top_test.sv -----
// ----------------------------------------------------------------------------
// binary_mask_mcc_f1_metric_top_test
// Streams pixel-pair frames into the metric block, predicts the MCC and F1
// of each frame from its own confusion counts and checks every result item.
// ----------------------------------------------------------------------------
module binary_mask_mcc_f1_metric_top_test;
  timeunit 1ns;
  timeprecision 1ps;
  import bmm_pkg::*;

  localparam int FRAC      = FRAC_BITS_DEF;
  localparam int CNT_CEIL  = (MAX_PIXELS_DEF < 8388607) ? MAX_PIXELS_DEF : 8388607;
  localparam int CYCLE_CAP = 1500000;
  localparam int DRAIN     = 2 * (96 + 2 * FRAC) + 2 * (FRAC + 1) + 19;

  logic clk = 1'b0;
  logic rst = 1'b1;

  bmm_pixel_if  pixel ();
  bmm_result_if result ();

  binary_mask_mcc_f1_metric_top uut (
    .clk    (clk),
    .rst    (rst),
    .pixel  (pixel.sink),
    .result (result.source)
  );

  always #1 clk = ~clk;

  // frame counts as seen by the predictor
  int unsigned cnt_tp, cnt_tn, cnt_fp, cnt_fn;
  bit          cnt_sat;
  result_t     metric_q[$];
  int          mismatches = 0;
  int          cycles = 0;
  bit          calm = 1'b0;

  function automatic bit idle_now();
    return !calm && ($urandom_range(99) < 20);
  endfunction

  // metrics of one frame from its confusion counts
  function automatic result_t frame_metrics(int unsigned tp, int unsigned tn,
                                            int unsigned fp, int unsigned fn, bit sat);
    result_t        m;
    logic [191:0]   ab, nn, t, c, q, mag, p1, p2;
    longint         mcc;
    longint unsigned f1;
    bit             neg;
    m.ovf    = sat;
    m.mcc_fb = (tp + fn == 0) || (tp + fp == 0) || (tn + fn == 0) || (tn + fp == 0);
    if (m.mcc_fb) begin
      mcc = (fn == fp) ? (64'd1 << FRAC) : 0;
    end else begin
      p1  = 192'(tp) * 192'(tn);
      p2  = 192'(fp) * 192'(fn);
      neg = p2 > p1;
      mag = neg ? p2 - p1 : p1 - p2;
      ab  = 192'(tp + fn) * 192'(tp + fp) * 192'(tn + fn) * 192'(tn + fp);
      nn  = (mag * mag) << (2 * FRAC);
      q   = '0;
      for (int b = FRAC; b >= 0; b--) begin
        c = q | (192'd1 << b);
        t = c * c * ab;
        if (t <= nn) q = c;
      end
      mcc = neg ? -longint'(q[63:0]) : longint'(q[63:0]);
    end
    if (mcc > 32767) mcc = 32767;
    if (mcc < -32768) mcc = -32768;
    m.mcc   = mcc[15:0];
    m.f1_fb = (tp == 0);
    if (m.f1_fb) f1 = (fn == fp) ? (64'd1 << FRAC) : 0;
    else f1 = (64'(2 * tp) << FRAC) / 64'(2 * tp + fp + fn);
    if (f1 > 32767) f1 = 32767;
    m.f1 = f1[14:0];
    return m;
  endfunction

  // count one accepted pixel pair, queue metrics on the last one
  task automatic count_pixel(logic [7:0] r, logic [7:0] s, logic l);
    if (r != 0 && s != 0) begin
      if (cnt_tp >= CNT_CEIL) cnt_sat = 1; else cnt_tp++;
    end else if (r == 0 && s == 0) begin
      if (cnt_tn >= CNT_CEIL) cnt_sat = 1; else cnt_tn++;
    end else if (s != 0) begin
      if (cnt_fp >= CNT_CEIL) cnt_sat = 1; else cnt_fp++;
    end else begin
      if (cnt_fn >= CNT_CEIL) cnt_sat = 1; else cnt_fn++;
    end
    if (l) begin
      metric_q.push_back(frame_metrics(cnt_tp, cnt_tn, cnt_fp, cnt_fn, cnt_sat));
      cnt_tp = 0; cnt_tn = 0; cnt_fp = 0; cnt_fn = 0; cnt_sat = 0;
    end
  endtask

  // drive one item and wait for its handshake
  task automatic send_pixel(logic [7:0] r, logic [7:0] s, logic l);
    while (idle_now()) begin
      pixel.valid = 1'b0;
      @(negedge clk);
    end
    pixel.valid      = 1'b1;
    pixel.ref_pixel  = r;
    pixel.seg_pixel  = s;
    pixel.last_pixel = l;
    do @(posedge clk); while (!pixel.ready);
    count_pixel(r, s, l);
    @(negedge clk);
    pixel.valid = 1'b0;
  endtask

  task automatic send_frame(int n, logic [7:0] r, logic [7:0] s);
    for (int i = 0; i < n; i++) send_pixel(r, s, i == n - 1);
  endtask

  task automatic wait_drained();
    while (metric_q.size() != 0) @(negedge clk);
  endtask

  // extremes of pixel values and every fallback case
  task automatic test_directed();
    send_frame(3, 8'd255, 8'd255);  // all true positives
    send_frame(2, 8'd0, 8'd0);      // all true negatives, equal foreground
    send_frame(2, 8'd0, 8'd1);      // false positives only
    send_frame(2, 8'd128, 8'd0);    // false negatives only
    send_pixel(8'd1, 8'd0, 1'b0);   // one fp and one fn, no tp
    send_pixel(8'd0, 8'd1, 1'b1);
    send_pixel(8'd255, 8'd1, 1'b0); // full confusion matrix
    send_pixel(8'd0, 8'd0, 1'b0);
    send_pixel(8'd0, 8'd255, 1'b0);
    send_pixel(8'd127, 8'd0, 1'b1);
    send_pixel(8'd1, 8'd0, 1'b0);   // perfect negative correlation
    send_pixel(8'd0, 8'd2, 1'b1);
    send_pixel(8'd64, 8'd32, 1'b0); // perfect positive correlation
    send_pixel(8'd0, 8'd0, 1'b1);
  endtask

  // sender holds off until every metric item has come back
  task automatic test_hold_off();
    wait_drained();
    send_frame(4, 8'd16, 8'd8);
    wait_drained();
    send_pixel(8'd4, 8'd2, 1'b1);
  endtask

  // random frames, mostly short with a few long ones
  task automatic test_random(int items);
    int sent = 0;
    int len, pr, ps;
    logic [7:0] r, s;
    while (sent < items) begin
      calm = (sent > items / 3) && (sent < items / 2);
      len  = ($urandom_range(9) == 0) ? $urandom_range(200, 20) : $urandom_range(12, 1);
      pr   = $urandom_range(100);
      ps   = $urandom_range(100);
      for (int i = 0; i < len; i++) begin
        r = ($urandom_range(99) < pr) ? 8'($urandom_range(255, 1)) : 8'd0;
        s = ($urandom_range(3) == 0) ? r : ($urandom_range(99) < ps) ?
            8'($urandom_range(255, 1)) : 8'd0;
        if ($urandom_range(19) == 0) r = 8'($urandom);
        send_pixel(r, s, i == len - 1);
      end
      sent += len;
    end
    calm = 1'b0;
  endtask

  // result sink: random backpressure at the falling edge
  always @(negedge clk) begin
    if (rst) result.ready <= 1'b0;
    else result.ready <= !idle_now();
  end

  // compare each accepted result item with the oldest prediction
  always @(posedge clk) begin
    result_t want;
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("timeout after %0d cycles", cycles);
      $display("RESULT: ERROR");
      $finish;
    end
    if (!rst && result.valid && result.ready) begin
      if (metric_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result item mcc=%0d", result.mcc_value);
      end else begin
        want = metric_q.pop_front();
        if (result.mcc_value !== want.mcc || result.f1_value !== want.f1 ||
            result.mcc_fallback !== want.mcc_fb || result.f1_fallback !== want.f1_fb ||
            result.count_overflow !== want.ovf) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch: exp mcc=%0d f1=%0d fb=%b%b ovf=%b",
                     want.mcc, want.f1, want.mcc_fb, want.f1_fb, want.ovf);
            $display("          got mcc=%0d f1=%0d fb=%b%b ovf=%b",
                     result.mcc_value, result.f1_value, result.mcc_fallback,
                     result.f1_fallback, result.count_overflow);
          end
        end
      end
    end
  end

  initial begin
    pixel.valid      = 1'b0;
    pixel.ref_pixel  = '0;
    pixel.seg_pixel  = '0;
    pixel.last_pixel = 1'b0;
    result.ready     = 1'b0;
    cnt_tp = 0; cnt_tn = 0; cnt_fp = 0; cnt_fn = 0; cnt_sat = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_directed();
    test_hold_off();
    test_random(1700);
    wait_drained();
    repeat (DRAIN) @(negedge clk);
    if (mismatches == 0 && metric_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule

// ----- filelist.f -----
hw/rtl/bmm_pkg.sv
hw/rtl/bmm_pixel_if.sv
hw/rtl/bmm_result_if.sv
hw/rtl/bmm_queue.sv
hw/rtl/bmm_front.sv
hw/rtl/bmm_calc.sv
hw/rtl/bmm_back.sv
hw/rtl/binary_mask_mcc_f1_metric_top.sv
bench/binary_mask_mcc_f1_metric_top_test.sv
